/* hw/rtl/erm_pkg.sv */
`timescale 1ns / 1ps

package erm_pkg;

    // CORDIC dimensions and datapath widths.
    localparam int CORDIC_STEPS = 28;
    localparam int CW = 50;
    localparam int SW = 17;
    localparam int ROOT_W = 31;
    localparam int CS_W = 33;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 50'sd652032874;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

    typedef enum logic {
        CMD_FORWARD = 1'b0,
        CMD_INVERSE = 1'b1
    } erm_cmd_t;

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } erm_quad_t;

    typedef struct packed {
        erm_cmd_t           command;
        logic        [15:0] yaw_angle;
        logic        [15:0] pitch_angle;
        logic        [15:0] roll_angle;
        logic signed [15:0] m_r00;
        logic signed [15:0] m_r10;
        logic signed [15:0] m_r20;
        logic signed [15:0] m_r21;
        logic signed [15:0] m_r22;
    } erm_item_t;

    typedef struct packed {
        erm_item_t              item;
        logic signed [SW-1:0]   s;
        logic [ROOT_W-1:0]      c;
    } erm_vec_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          z;
        erm_quad_t            q;
        logic                 zero;
    } erm_lane_t;

    typedef struct packed {
        erm_cmd_t        command;
        logic [15:0]     yaw_angle;
        logic [15:0]     pitch_angle;
        logic [15:0]     roll_angle;
        erm_lane_t [2:0] lane;
    } erm_cordic_t;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } erm_result_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input int unsigned i);
        logic [31:0] r;
        case (i)
            0:       r = 32'h20000000;
            1:       r = 32'h12E4051D;
            2:       r = 32'h09FB385B;
            3:       r = 32'h051111D4;
            4:       r = 32'h028B0D43;
            5:       r = 32'h0145D7E1;
            6:       r = 32'h00A2F61E;
            7:       r = 32'h00517C55;
            8:       r = 32'h0028BE53;
            9:       r = 32'h00145F2E;
            10:      r = 32'h000A2F98;
            11:      r = 32'h000517CC;
            12:      r = 32'h00028BE6;
            13:      r = 32'h000145F3;
            14:      r = 32'h0000A2F9;
            15:      r = 32'h0000517C;
            16:      r = 32'h000028BE;
            17:      r = 32'h0000145F;
            18:      r = 32'h00000A2F;
            19:      r = 32'h00000517;
            20:      r = 32'h0000028B;
            21:      r = 32'h00000145;
            22:      r = 32'h000000A2;
            23:      r = 32'h00000051;
            24:      r = 32'h00000028;
            25:      r = 32'h00000014;
            26:      r = 32'h0000000A;
            27:      r = 32'h00000005;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // Product of two values with 30 fraction bits, rounded back to 30 fraction bits.
    function automatic logic signed [CS_W-1:0] qmul(input logic signed [CS_W-1:0] a,
                                                    input logic signed [CS_W-1:0] b);
        logic signed [2*CS_W-1:0] p;
        p = a * b;
        p = p + ((2*CS_W)'(1) <<< 29);
        return CS_W'(p >>> 30);
    endfunction

endpackage

/* hw/rtl/erm_if.sv */
`timescale 1ns / 1ps

// Request channel: one attitude item.
interface erm_req_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [15:0] m_r00;
    logic signed [15:0] m_r10;
    logic signed [15:0] m_r20;
    logic signed [15:0] m_r21;
    logic signed [15:0] m_r22;

    modport source (
        output valid, command, yaw_angle, pitch_angle, roll_angle,
        output m_r00, m_r10, m_r20, m_r21, m_r22,
        input  ready
    );
    modport sink (
        input  valid, command, yaw_angle, pitch_angle, roll_angle,
        input  m_r00, m_r10, m_r20, m_r21, m_r22,
        output ready
    );
endinterface

// Response channel: matrix entries and angles.
interface erm_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_r00;
    logic signed [15:0] out_r01;
    logic signed [15:0] out_r02;
    logic signed [15:0] out_r10;
    logic signed [15:0] out_r11;
    logic signed [15:0] out_r12;
    logic signed [15:0] out_r20;
    logic signed [15:0] out_r21;
    logic signed [15:0] out_r22;
    logic signed [15:0] out_yaw;
    logic signed [15:0] out_pitch;
    logic signed [15:0] out_roll;

    modport source (
        output valid, out_r00, out_r01, out_r02, out_r10, out_r11, out_r12,
        output out_r20, out_r21, out_r22, out_yaw, out_pitch, out_roll,
        input  ready
    );
    modport sink (
        input  valid, out_r00, out_r01, out_r02, out_r10, out_r11, out_r12,
        input  out_r20, out_r21, out_r22, out_yaw, out_pitch, out_roll,
        output ready
    );
endinterface

/* hw/rtl/erm_isqrt.sv */
`timescale 1ns / 1ps

module erm_isqrt #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  erm_pkg::erm_item_t in_item,
    output logic               out_valid,
    output erm_pkg::erm_vec_t  out_vec
);
    import erm_pkg::*;

    localparam int VW = 2 * COEF_FRAC_BITS + 2;
    localparam int NST = COEF_FRAC_BITS + 1;
    localparam logic signed [31:0] LIM = 32'sd1 <<< COEF_FRAC_BITS;
    localparam logic [VW-1:0] LIM2 = VW'(1) << (2 * COEF_FRAC_BITS);

    erm_item_t            item_a_reg;
    logic signed [SW-1:0] s_a_reg;
    logic                 vld_a_reg;
    logic signed [SW-1:0] s_a_next;

    erm_item_t            item_reg [NST+1];
    logic signed [SW-1:0] s_reg [NST+1];
    logic [VW-1:0]        v_reg [NST+1];
    logic [VW-1:0]        res_reg [NST+1];
    logic                 vld_reg [NST+1];
    logic [VW-1:0]        v_b_next;
    logic signed [2*SW-1:0] sq;

    // Saturate the asin operand to plus or minus one.
    always_comb
    begin
        logic signed [31:0] sw;
        sw = 32'(in_item.m_r20);
        if (sw > LIM)
        begin
            sw = LIM;
        end
        if (sw < -LIM)
        begin
            sw = -LIM;
        end
        s_a_next = SW'(sw);
    end

    // Radicand: one minus the squared sine.
    always_comb
    begin
        sq = s_a_reg * s_a_reg;
        v_b_next = LIM2 - VW'(sq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg  <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg  <= in_valid;
            vld_reg[0] <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_a_reg  <= in_item;
            s_a_reg     <= s_a_next;
            item_reg[0] <= item_a_reg;
            s_reg[0]    <= s_a_reg;
            v_reg[0]    <= v_b_next;
            res_reg[0]  <= '0;
        end
    end

    // One result bit per stage, most significant first.
    for (genvar j = 0; j < NST; j++)
    begin : g_bit
        localparam logic [VW-1:0] BITV = VW'(1) << (2 * (COEF_FRAC_BITS - j));
        logic [VW-1:0] v_next;
        logic [VW-1:0] res_next;

        always_comb
        begin
            if (v_reg[j] >= res_reg[j] + BITV)
            begin
                v_next   = v_reg[j] - (res_reg[j] + BITV);
                res_next = (res_reg[j] >> 1) + BITV;
            end
            else
            begin
                v_next   = v_reg[j];
                res_next = res_reg[j] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg[j+1] <= item_reg[j];
                s_reg[j+1]    <= s_reg[j];
                v_reg[j+1]    <= v_next;
                res_reg[j+1]  <= res_next;
            end
        end
    end

    assign out_valid    = vld_reg[NST];
    assign out_vec.item = item_reg[NST];
    assign out_vec.s    = s_reg[NST];
    assign out_vec.c    = ROOT_W'(res_reg[NST]);

endmodule

/* hw/rtl/erm_cordic.sv */
`timescale 1ns / 1ps

module erm_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  erm_pkg::erm_vec_t    in_vec,
    output logic                 out_valid,
    output erm_pkg::erm_cordic_t out_data
);
    import erm_pkg::*;

    localparam logic [31:0] AMASK =
        (ANGLE_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << ANGLE_BITS) - 32'd1);

    erm_cordic_t init_next;
    erm_cordic_t st_reg [CORDIC_STEPS+1];
    erm_cordic_t st_next [CORDIC_STEPS];
    logic        vld_reg [CORDIC_STEPS+1];

    // Binary angle to a 32-bit fraction of a turn.
    function automatic logic [31:0] angle_in(input logic [15:0] raw);
        logic [31:0] m;
        m = {16'b0, raw} & AMASK;
        return m << (32 - ANGLE_BITS);
    endfunction

    // Rotation mode start: fold to within an eighth turn by whole quadrants.
    function automatic erm_lane_t rot_init(input logic [15:0] raw);
        erm_lane_t   l;
        logic [31:0] a;
        logic [31:0] t;
        a      = angle_in(raw);
        t      = a + EIGHTH_TURN;
        l.q    = erm_quad_t'(t[31:30]);
        l.z    = a - {t[31:30], 30'b0};
        l.x    = CORDIC_GAIN;
        l.y    = '0;
        l.zero = 1'b0;
        return l;
    endfunction

    // Vectoring mode start: scale up and turn the left half plane over.
    function automatic erm_lane_t vec_init(input logic signed [31:0] yv,
                                           input logic signed [31:0] xv);
        erm_lane_t l;
        l.x    = CW'(xv) <<< 16;
        l.y    = CW'(yv) <<< 16;
        l.z    = '0;
        l.q    = QUAD_0;
        l.zero = (xv == 32'sd0) && (yv == 32'sd0);
        if (xv < 32'sd0)
        begin
            l.x = -l.x;
            l.y = -l.y;
            l.z = HALF_TURN;
        end
        return l;
    endfunction

    always_comb
    begin
        init_next.command     = in_vec.item.command;
        init_next.yaw_angle   = in_vec.item.yaw_angle;
        init_next.pitch_angle = in_vec.item.pitch_angle;
        init_next.roll_angle  = in_vec.item.roll_angle;
        if (in_vec.item.command == CMD_FORWARD)
        begin
            init_next.lane[0] = rot_init(in_vec.item.yaw_angle);
            init_next.lane[1] = rot_init(in_vec.item.pitch_angle);
            init_next.lane[2] = rot_init(in_vec.item.roll_angle);
        end
        else
        begin
            init_next.lane[0] = vec_init(32'(in_vec.item.m_r10), 32'(in_vec.item.m_r00));
            init_next.lane[1] = vec_init(32'(in_vec.s), $signed({1'b0, in_vec.c}));
            init_next.lane[2] = vec_init(32'(in_vec.item.m_r21), 32'(in_vec.item.m_r22));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= init_next;
        end
    end

    // One micro-rotation per stage on all three lanes.
    for (genvar j = 0; j < CORDIC_STEPS; j++)
    begin : g_step
        localparam logic [31:0] ATAN = atan_turn(j);

        always_comb
        begin
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;
            logic                 pos;
            st_next[j] = st_reg[j];
            for (int l = 0; l < 3; l++)
            begin
                dx = st_reg[j].lane[l].y >>> j;
                dy = st_reg[j].lane[l].x >>> j;
                if (st_reg[j].command == CMD_FORWARD)
                begin
                    pos = !st_reg[j].lane[l].z[31];
                end
                else
                begin
                    pos = st_reg[j].lane[l].y[CW-1] || (st_reg[j].lane[l].y == '0);
                end
                if (pos)
                begin
                    st_next[j].lane[l].x = st_reg[j].lane[l].x - dx;
                    st_next[j].lane[l].y = st_reg[j].lane[l].y + dy;
                    st_next[j].lane[l].z = st_reg[j].lane[l].z - ATAN;
                end
                else
                begin
                    st_next[j].lane[l].x = st_reg[j].lane[l].x + dx;
                    st_next[j].lane[l].y = st_reg[j].lane[l].y - dy;
                    st_next[j].lane[l].z = st_reg[j].lane[l].z + ATAN;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[j+1] <= st_next[j];
            end
        end
    end

    assign out_valid = vld_reg[CORDIC_STEPS];
    assign out_data  = st_reg[CORDIC_STEPS];

endmodule

/* hw/rtl/erm_matrix.sv */
`timescale 1ns / 1ps

module erm_matrix #(
    parameter int ANGLE_BITS = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  erm_pkg::erm_cordic_t in_data,
    output logic                 out_valid,
    output erm_pkg::erm_result_t out_data
);
    import erm_pkg::*;

    localparam int EW = CS_W + 2;
    localparam int SH = 30 - COEF_FRAC_BITS;
    localparam logic signed [EW-1:0] RND = (SH > 0) ? (EW'(1) <<< (SH - 1)) : EW'(0);
    localparam logic signed [EW-1:0] LIM = EW'(1) <<< COEF_FRAC_BITS;
    localparam logic [31:0] HALF =
        (ANGLE_BITS < 32) ? (32'd1 << (31 - ANGLE_BITS)) : 32'd0;
    localparam logic [31:0] AMASK =
        (ANGLE_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << ANGLE_BITS) - 32'd1);
    localparam logic signed [33:0] QUARTER = 34'sd1 <<< (ANGLE_BITS - 2);
    localparam logic signed [33:0] FULL = 34'sd1 <<< ANGLE_BITS;

    typedef logic signed [CS_W-1:0] cs_t;

    // Stage 0: quadrant mapping and angle conversion.
    logic        vld0_reg;
    erm_cmd_t    cmd0_reg;
    logic [15:0] echo0_reg [3];
    logic [15:0] inv0_reg [3];
    cs_t         c0_reg [3];
    cs_t         s0_reg [3];
    cs_t         c0_next [3];
    cs_t         s0_next [3];
    logic [15:0] inv0_next [3];

    // Stage 1: first products.
    logic        vld1_reg;
    erm_cmd_t    cmd1_reg;
    logic [15:0] echo1_reg [3];
    logic [15:0] inv1_reg [3];
    cs_t cysp1_reg, sysp1_reg, cycp1_reg, sycp1_reg, sycr1_reg;
    cs_t sysr1_reg, cycr1_reg, cysr1_reg, cpsr1_reg, cpcr1_reg;
    cs_t sp1_reg, sr1_reg, cr1_reg;

    // Stage 2: triple products.
    logic        vld2_reg;
    erm_cmd_t    cmd2_reg;
    logic [15:0] echo2_reg [3];
    logic [15:0] inv2_reg [3];
    cs_t cyspsr2_reg, cyspcr2_reg, syspsr2_reg, syspcr2_reg;
    cs_t cycp2_reg, sycp2_reg, sycr2_reg, sysr2_reg, cycr2_reg, cysr2_reg;
    cs_t cpsr2_reg, cpcr2_reg, sp2_reg;

    // Stage 3: output register.
    logic        vld3_reg;
    erm_result_t res3_reg;
    erm_result_t res3_next;

    function automatic logic [31:0] angle_out(input logic [31:0] z);
        logic [31:0] t;
        t = z + HALF;
        return t >> (32 - ANGLE_BITS);
    endfunction

    function automatic logic [15:0] coef_out(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] r;
        r = (v + RND) >>> SH;
        if (r > LIM)
        begin
            r = LIM;
        end
        if (r < -LIM)
        begin
            r = -LIM;
        end
        return r[15:0];
    endfunction

    function automatic logic signed [EW-1:0] ext(input cs_t v);
        return EW'(v);
    endfunction

    always_comb
    begin
        logic [31:0]        au [3];
        logic signed [33:0] ps;
        logic [31:0]        rn;
        cs_t                xs;
        cs_t                ys;
        for (int l = 0; l < 3; l++)
        begin
            xs = CS_W'(in_data.lane[l].x);
            ys = CS_W'(in_data.lane[l].y);
            case (in_data.lane[l].q)
                QUAD_0:
                begin
                    c0_next[l] = xs;
                    s0_next[l] = ys;
                end
                QUAD_90:
                begin
                    c0_next[l] = -ys;
                    s0_next[l] = xs;
                end
                QUAD_180:
                begin
                    c0_next[l] = -xs;
                    s0_next[l] = -ys;
                end
                default:
                begin
                    c0_next[l] = ys;
                    s0_next[l] = -xs;
                end
            endcase
            au[l] = in_data.lane[l].zero ? 32'd0 : angle_out(in_data.lane[l].z);
        end
        inv0_next[0] = au[0][15:0];
        // Pitch as a signed angle, kept within a quarter turn.
        if (au[1][ANGLE_BITS-1])
        begin
            ps = $signed({2'b0, au[1]}) - FULL;
        end
        else
        begin
            ps = $signed({2'b0, au[1]});
        end
        if (ps > QUARTER)
        begin
            ps = QUARTER;
        end
        if (ps < -QUARTER)
        begin
            ps = -QUARTER;
        end
        inv0_next[1] = ps[15:0];
        rn = (32'd0 - au[2]) & AMASK;
        inv0_next[2] = rn[15:0];
    end

    always_comb
    begin
        if (cmd2_reg == CMD_FORWARD)
        begin
            res3_next.r00   = coef_out(ext(cycp2_reg));
            res3_next.r01   = coef_out(ext(cyspsr2_reg) - ext(sycr2_reg));
            res3_next.r02   = coef_out(-ext(cyspcr2_reg) - ext(sysr2_reg));
            res3_next.r10   = coef_out(ext(sycp2_reg));
            res3_next.r11   = coef_out(ext(syspsr2_reg) + ext(cycr2_reg));
            res3_next.r12   = coef_out(-ext(syspcr2_reg) + ext(cysr2_reg));
            res3_next.r20   = coef_out(ext(sp2_reg));
            res3_next.r21   = coef_out(-ext(cpsr2_reg));
            res3_next.r22   = coef_out(ext(cpcr2_reg));
            res3_next.yaw   = echo2_reg[0];
            res3_next.pitch = echo2_reg[1];
            res3_next.roll  = echo2_reg[2];
        end
        else
        begin
            res3_next       = '0;
            res3_next.yaw   = inv2_reg[0];
            res3_next.pitch = inv2_reg[1];
            res3_next.roll  = inv2_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= in_valid;
            vld1_reg <= vld0_reg;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 0.
            cmd0_reg     <= in_data.command;
            echo0_reg[0] <= in_data.yaw_angle;
            echo0_reg[1] <= in_data.pitch_angle;
            echo0_reg[2] <= in_data.roll_angle;
            inv0_reg     <= inv0_next;
            c0_reg       <= c0_next;
            s0_reg       <= s0_next;
            // Stage 1: lane 0 is yaw, lane 1 pitch, lane 2 roll.
            cmd1_reg  <= cmd0_reg;
            echo1_reg <= echo0_reg;
            inv1_reg  <= inv0_reg;
            cysp1_reg <= qmul(c0_reg[0], s0_reg[1]);
            sysp1_reg <= qmul(s0_reg[0], s0_reg[1]);
            cycp1_reg <= qmul(c0_reg[0], c0_reg[1]);
            sycp1_reg <= qmul(s0_reg[0], c0_reg[1]);
            sycr1_reg <= qmul(s0_reg[0], c0_reg[2]);
            sysr1_reg <= qmul(s0_reg[0], s0_reg[2]);
            cycr1_reg <= qmul(c0_reg[0], c0_reg[2]);
            cysr1_reg <= qmul(c0_reg[0], s0_reg[2]);
            cpsr1_reg <= qmul(c0_reg[1], s0_reg[2]);
            cpcr1_reg <= qmul(c0_reg[1], c0_reg[2]);
            sp1_reg   <= s0_reg[1];
            sr1_reg   <= s0_reg[2];
            cr1_reg   <= c0_reg[2];
            // Stage 2.
            cmd2_reg    <= cmd1_reg;
            echo2_reg   <= echo1_reg;
            inv2_reg    <= inv1_reg;
            cyspsr2_reg <= qmul(cysp1_reg, sr1_reg);
            cyspcr2_reg <= qmul(cysp1_reg, cr1_reg);
            syspsr2_reg <= qmul(sysp1_reg, sr1_reg);
            syspcr2_reg <= qmul(sysp1_reg, cr1_reg);
            cycp2_reg   <= cycp1_reg;
            sycp2_reg   <= sycp1_reg;
            sycr2_reg   <= sycr1_reg;
            sysr2_reg   <= sysr1_reg;
            cycr2_reg   <= cycr1_reg;
            cysr2_reg   <= cysr1_reg;
            cpsr2_reg   <= cpsr1_reg;
            cpcr2_reg   <= cpcr1_reg;
            sp2_reg     <= sp1_reg;
            // Stage 3.
            res3_reg <= res3_next;
        end
    end

    assign out_valid = vld3_reg;
    assign out_data  = res3_reg;

endmodule

/* hw/rtl/euler_rotation_matrix_top.sv */
`timescale 1ns / 1ps

// Euler angle and rotation matrix converter (yaw, pitch, roll; R = Ryaw*Rpitch*Rroll).
// The request channel carries one item: a command bit, three binary angles and
// five matrix entries. Command 0 turns the angles into all nine Q2.14 entries
// and echoes the angles; command 1 recovers yaw, pitch and roll from the entries
// and returns a zero matrix.
// The response channel carries one item per request item, in order.
// The pipeline is an integer square root of COEF_FRAC_BITS + 3 stages, a 29-stage
// CORDIC with three lanes and four stages of multipliers and output formatting.
// Throughput is one item per cycle; every stage is a register with a valid bit.
// When the receiver holds ready low while a result waits, the whole pipeline
// freezes and request ready drops in the same cycle; nothing is lost or repeated.
// Reset clears the valid bits only; the data registers are not reset.
module euler_rotation_matrix_top #(
    parameter int ANGLE_BITS = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input logic        clk,
    input logic        rst_n,
    erm_req_if.sink    request,
    erm_rsp_if.source  response
);
    import erm_pkg::*;

    logic        en;
    erm_item_t   item;
    logic        sq_valid;
    erm_vec_t    sq_vec;
    logic        cd_valid;
    erm_cordic_t cd_data;
    logic        mx_valid;
    erm_result_t mx_data;

    // Global advance: move unless a finished item is stuck at the output.
    assign en            = !mx_valid || response.ready;
    assign request.ready = en;

    always_comb
    begin
        item.command     = erm_cmd_t'(request.command);
        item.yaw_angle   = request.yaw_angle;
        item.pitch_angle = request.pitch_angle;
        item.roll_angle  = request.roll_angle;
        item.m_r00       = request.m_r00;
        item.m_r10       = request.m_r10;
        item.m_r20       = request.m_r20;
        item.m_r21       = request.m_r21;
        item.m_r22       = request.m_r22;
    end

    erm_isqrt #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (request.valid),
        .in_item  (item),
        .out_valid(sq_valid),
        .out_vec  (sq_vec)
    );

    erm_cordic #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sq_valid),
        .in_vec   (sq_vec),
        .out_valid(cd_valid),
        .out_data (cd_data)
    );

    erm_matrix #(
        .ANGLE_BITS    (ANGLE_BITS),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_matrix (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (cd_valid),
        .in_data  (cd_data),
        .out_valid(mx_valid),
        .out_data (mx_data)
    );

    assign response.valid     = mx_valid;
    assign response.out_r00   = mx_data.r00;
    assign response.out_r01   = mx_data.r01;
    assign response.out_r02   = mx_data.r02;
    assign response.out_r10   = mx_data.r10;
    assign response.out_r11   = mx_data.r11;
    assign response.out_r12   = mx_data.r12;
    assign response.out_r20   = mx_data.r20;
    assign response.out_r21   = mx_data.r21;
    assign response.out_r22   = mx_data.r22;
    assign response.out_yaw   = mx_data.yaw;
    assign response.out_pitch = mx_data.pitch;
    assign response.out_roll  = mx_data.roll;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import erm_pkg::*;

    localparam int LATENCY = 50;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int DIRECTED_ITEMS = 22;

    // 28 CORDIC steps; each entry is atan(2^-i) in units of 2^-32 turn.
    localparam logic [31:0] ARC_STEP [28] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

    // One row of the directed table; has_ref marks rows with a typed result.
    typedef struct {
        erm_item_t   stim;
        bit          has_ref;
        erm_result_t ref_res;
    } attitude_row_t;

    logic clk;
    logic rst_n;
    int   error_count;
    int   idle_cycles;
    bit   stim_done;

    erm_req_if request ();
    erm_rsp_if response ();

    erm_result_t matrix_queue[$];

    euler_rotation_matrix_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Rotation-mode CORDIC giving cosine and sine with 30 fraction bits.
    function automatic void cordic_sincos(input logic [31:0] ang, output longint c,
                                          output longint s);
        logic [31:0] quad;
        logic [31:0] zu;
        longint z;
        longint x;
        longint y;
        longint nx;
        quad = ((ang + 32'h2000_0000) >> 30) & 32'd3;
        zu = ang - (quad << 30);
        z = longint'($signed(zu));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 28; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ARC_STEP[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ARC_STEP[i]);
            end
            x = nx;
        end
        case (quad[1:0])
            2'd0:
            begin
                c = x;
                s = y;
            end
            2'd1:
            begin
                c = -y;
                s = x;
            end
            2'd2:
            begin
                c = -x;
                s = -y;
            end
            default:
            begin
                c = y;
                s = -x;
            end
        endcase
    endfunction

    // Vectoring-mode CORDIC; returns the angle in 2^-32 turns.
    function automatic logic [31:0] vector_angle(longint y, longint x);
        logic [31:0] z;
        longint nx;
        z = 32'd0;
        if (x == 0 && y == 0)
        begin
            return 32'd0;
        end
        x = x * 65536;
        y = y * 65536;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < 28; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ARC_STEP[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ARC_STEP[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint round30(longint a, longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic logic [15:0] to_binary_angle(logic [31:0] z);
        logic [31:0] t;
        t = z + 32'h0000_8000;
        return t[31:16];
    endfunction

    function automatic logic signed [15:0] to_q14(longint v);
        longint r;
        r = (v + (longint'(1) << 15)) >>> 16;
        if (r > 16384)
        begin
            r = 16384;
        end
        if (r < -16384)
        begin
            r = -16384;
        end
        return 16'(r);
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint r;
        r = 0;
        for (int b = 15; b >= 0; b--)
        begin
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= v)
            begin
                r = r + (longint'(1) << b);
            end
        end
        return r;
    endfunction

    // Expected output of the converter for one request item.
    function automatic erm_result_t attitude_convert(erm_item_t it);
        erm_result_t r;
        longint cy, sy, cp, sp, cr, sr, cysp, sysp;
        longint s, c, p;
        logic [15:0] pu;
        logic [15:0] roll_pos;
        r = '0;
        if (it.command == CMD_FORWARD)
        begin
            cordic_sincos({it.yaw_angle, 16'h0}, cy, sy);
            cordic_sincos({it.pitch_angle, 16'h0}, cp, sp);
            cordic_sincos({it.roll_angle, 16'h0}, cr, sr);
            cysp = round30(cy, sp);
            sysp = round30(sy, sp);
            r.r00 = to_q14(round30(cy, cp));
            r.r01 = to_q14(round30(cysp, sr) - round30(sy, cr));
            r.r02 = to_q14(-round30(cysp, cr) - round30(sy, sr));
            r.r10 = to_q14(round30(sy, cp));
            r.r11 = to_q14(round30(sysp, sr) + round30(cy, cr));
            r.r12 = to_q14(-round30(sysp, cr) + round30(cy, sr));
            r.r20 = to_q14(sp);
            r.r21 = to_q14(-round30(cp, sr));
            r.r22 = to_q14(round30(cp, cr));
            r.yaw = it.yaw_angle;
            r.pitch = it.pitch_angle;
            r.roll = it.roll_angle;
        end
        else
        begin
            r.yaw = to_binary_angle(vector_angle(longint'(it.m_r10), longint'(it.m_r00)));
            s = longint'(it.m_r20);
            if (s > 16384)
            begin
                s = 16384;
            end
            if (s < -16384)
            begin
                s = -16384;
            end
            c = floor_sqrt(longint'(16384) * 16384 - s * s);
            pu = to_binary_angle(vector_angle(s, c));
            p = longint'($signed(pu));
            if (p > 16384)
            begin
                p = 16384;
            end
            if (p < -16384)
            begin
                p = -16384;
            end
            r.pitch = 16'(p);
            roll_pos = to_binary_angle(vector_angle(longint'(it.m_r21), longint'(it.m_r22)));
            r.roll = 16'(16'd0 - roll_pos);
        end
        return r;
    endfunction

    function automatic erm_item_t make_item(erm_cmd_t cmd, logic [15:0] y, logic [15:0] p,
                                            logic [15:0] rl, logic [15:0] a, logic [15:0] b,
                                            logic [15:0] c, logic [15:0] d, logic [15:0] e);
        erm_item_t it;
        it.command = cmd;
        it.yaw_angle = y;
        it.pitch_angle = p;
        it.roll_angle = rl;
        it.m_r00 = a;
        it.m_r10 = b;
        it.m_r20 = c;
        it.m_r21 = d;
        it.m_r22 = e;
        return it;
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 9))
            0:       return 16'(16384);
            1:       return 16'(-16384);
            2:       return 16'h0000;
            3:       return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // Random item, mostly legal rotation matrices or angles with full range noise.
    function automatic erm_item_t rand_item();
        erm_item_t it;
        erm_result_t m;
        it = make_item(erm_cmd_t'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                       16'($urandom), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                       rand_coef());
        if (it.command == CMD_INVERSE && $urandom_range(0, 2) != 0)
        begin
            // Build the matrix from random angles so the inverse sees consistent entries.
            m = attitude_convert(make_item(CMD_FORWARD, 16'($urandom), 16'($urandom),
                                           16'($urandom), 0, 0, 0, 0, 0));
            it.m_r00 = m.r00;
            it.m_r10 = m.r10;
            it.m_r20 = m.r20;
            it.m_r21 = m.r21;
            it.m_r22 = m.r22;
        end
        return it;
    endfunction

    // Drive one item; valid drops only for an idle gap before the item.
    task automatic send_item(erm_item_t it);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            request.valid <= 1'b0;
            repeat (gap)
            begin
                @(negedge clk);
            end
        end
        request.valid <= 1'b1;
        request.command <= it.command;
        request.yaw_angle <= it.yaw_angle;
        request.pitch_angle <= it.pitch_angle;
        request.roll_angle <= it.roll_angle;
        request.m_r00 <= it.m_r00;
        request.m_r10 <= it.m_r10;
        request.m_r20 <= it.m_r20;
        request.m_r21 <= it.m_r21;
        request.m_r22 <= it.m_r22;
        @(posedge clk);
        while (!request.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Stimulus: a directed table, then random items.
    initial
    begin
        attitude_row_t rows[DIRECTED_ITEMS];
        erm_result_t zero_res;
        erm_result_t fwd_zero;
        erm_item_t it;
        request.valid = 1'b0;
        request.command = 1'b0;
        request.yaw_angle = '0;
        request.pitch_angle = '0;
        request.roll_angle = '0;
        request.m_r00 = '0;
        request.m_r10 = '0;
        request.m_r20 = '0;
        request.m_r21 = '0;
        request.m_r22 = '0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        zero_res = '0;
        fwd_zero = '0;
        fwd_zero.r00 = 16'sd16384;
        fwd_zero.r11 = 16'sd16384;
        fwd_zero.r22 = 16'sd16384;
        rows[0] = '{make_item(CMD_FORWARD, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, fwd_zero};
        rows[1] = '{make_item(CMD_INVERSE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero_res};
        rows[2] = '{make_item(CMD_FORWARD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0, 0),
                    1'b0, zero_res};
        rows[3] = '{make_item(CMD_FORWARD, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, zero_res};
        rows[4] = '{make_item(CMD_FORWARD, 16'h4000, 16'h4000, 16'h4000, 0, 0, 0, 0, 0),
                    1'b0, zero_res};
        rows[5] = '{make_item(CMD_FORWARD, 16'hC000, 16'hC000, 16'hC000, 0, 0, 0, 0, 0),
                    1'b0, zero_res};
        rows[6] = '{make_item(CMD_FORWARD, 16'h2000, 16'hE000, 16'h6000, 0, 0, 0, 0, 0),
                    1'b0, zero_res};
        rows[7] = '{make_item(CMD_FORWARD, 16'hFFFF, 16'h0001, 16'h5555, 0, 0, 0, 0, 0),
                    1'b0, zero_res};
        rows[8] = '{make_item(CMD_INVERSE, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384),
                    1'b1, zero_res};
        rows[9] = '{make_item(CMD_INVERSE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sd16384, 0,
                              16'sd16384, 0, 16'sd16384), 1'b0, zero_res};
        rows[10] = '{make_item(CMD_INVERSE, 0, 0, 0, 0, 0, -16'sd16384, 0, 0), 1'b0, zero_res};
        rows[11] = '{make_item(CMD_INVERSE, 0, 0, 0, 0, 0, 16'h7FFF, 0, 0), 1'b0, zero_res};
        rows[12] = '{make_item(CMD_INVERSE, 0, 0, 0, 0, 0, 16'h8000, 0, 0), 1'b0, zero_res};
        rows[13] = '{make_item(CMD_INVERSE, 0, 0, 0, -16'sd16384, 0, 0, 0, -16'sd16384),
                     1'b0, zero_res};
        rows[14] = '{make_item(CMD_INVERSE, 0, 0, 0, -16'sd16384, -16'sd1, 0, 16'sd1,
                               -16'sd16384), 1'b0, zero_res};
        rows[15] = '{make_item(CMD_INVERSE, 0, 0, 0, 0, 16'sd16384, 0, -16'sd16384, 0),
                     1'b0, zero_res};
        rows[16] = '{make_item(CMD_INVERSE, 0, 0, 0, 0, -16'sd16384, 0, 16'sd16384, 0),
                     1'b0, zero_res};
        rows[17] = '{make_item(CMD_INVERSE, 0, 0, 0, 16'h7FFF, 16'h8000, 16'h2000, 16'h8000,
                               16'h7FFF), 1'b0, zero_res};
        rows[18] = '{make_item(CMD_INVERSE, 0, 0, 0, 16'h8000, 16'h7FFF, 16'hE000, 16'h7FFF,
                               16'h8000), 1'b0, zero_res};
        rows[19] = '{make_item(CMD_INVERSE, 0, 0, 0, 16'sd11585, 16'sd11585, 16'sd11585,
                               -16'sd11585, 16'sd11585), 1'b0, zero_res};
        rows[20] = '{make_item(CMD_FORWARD, 16'h1234, 16'h3FFF, 16'hABCD, 16'sd16384,
                               16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384), 1'b0, zero_res};
        rows[21] = '{make_item(CMD_FORWARD, 16'h0000, 16'h4000, 16'h0000, 0, 0, 0, 0, 0),
                     1'b0, zero_res};
        repeat (6)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (rows[i])
        begin
            matrix_queue.push_back(rows[i].has_ref ? rows[i].ref_res
                                                   : attitude_convert(rows[i].stim));
            send_item(rows[i].stim);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            it = rand_item();
            matrix_queue.push_back(attitude_convert(it));
            send_item(it);
        end
        request.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Response side: random stalls, with stretches of steady ready.
    initial
    begin
        int stall;
        response.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                response.ready <= 1'b0;
                repeat (stall)
                begin
                    @(negedge clk);
                end
            end
            response.ready <= 1'b1;
            @(posedge clk);
            while (!response.valid)
            begin
                @(posedge clk);
            end
        end
    end

    // Compare each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        erm_result_t exp_res;
        if (rst_n && response.valid && response.ready)
        begin
            if (matrix_queue.size() == 0)
            begin
                $error("Unexpected result item with nothing outstanding");
                error_count++;
            end
            else
            begin
                exp_res = matrix_queue.pop_front();
                if (response.out_r00 !== exp_res.r00)
                begin
                    $error("out_r00 expected %0d actual %0d", exp_res.r00, response.out_r00);
                    error_count++;
                end
                if (response.out_r01 !== exp_res.r01)
                begin
                    $error("out_r01 expected %0d actual %0d", exp_res.r01, response.out_r01);
                    error_count++;
                end
                if (response.out_r02 !== exp_res.r02)
                begin
                    $error("out_r02 expected %0d actual %0d", exp_res.r02, response.out_r02);
                    error_count++;
                end
                if (response.out_r10 !== exp_res.r10)
                begin
                    $error("out_r10 expected %0d actual %0d", exp_res.r10, response.out_r10);
                    error_count++;
                end
                if (response.out_r11 !== exp_res.r11)
                begin
                    $error("out_r11 expected %0d actual %0d", exp_res.r11, response.out_r11);
                    error_count++;
                end
                if (response.out_r12 !== exp_res.r12)
                begin
                    $error("out_r12 expected %0d actual %0d", exp_res.r12, response.out_r12);
                    error_count++;
                end
                if (response.out_r20 !== exp_res.r20)
                begin
                    $error("out_r20 expected %0d actual %0d", exp_res.r20, response.out_r20);
                    error_count++;
                end
                if (response.out_r21 !== exp_res.r21)
                begin
                    $error("out_r21 expected %0d actual %0d", exp_res.r21, response.out_r21);
                    error_count++;
                end
                if (response.out_r22 !== exp_res.r22)
                begin
                    $error("out_r22 expected %0d actual %0d", exp_res.r22, response.out_r22);
                    error_count++;
                end
                if (response.out_yaw !== exp_res.yaw)
                begin
                    $error("out_yaw expected %0d actual %0d", exp_res.yaw, response.out_yaw);
                    error_count++;
                end
                if (response.out_pitch !== exp_res.pitch)
                begin
                    $error("out_pitch expected %0d actual %0d", exp_res.pitch,
                           response.out_pitch);
                    error_count++;
                end
                if (response.out_roll !== exp_res.roll)
                begin
                    $error("out_roll expected %0d actual %0d", exp_res.roll, response.out_roll);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no item moves on either side.
    always @(posedge clk)
    begin
        if ((request.valid && request.ready) || (response.valid && response.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // End of run: drain, wait out the pipeline, then report.
    initial
    begin
        fork
            begin
                wait (stim_done && matrix_queue.size() == 0);
                repeat (LATENCY + 20)
                begin
                    @(posedge clk);
                end
                if (error_count == 0)
                begin
                    $display("Testbench completed without errors");
                end
                else
                begin
                    $display("Testbench completed WITH ERRORS");
                end
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                $error("Watchdog expired with %0d result items outstanding",
                       matrix_queue.size());
                $display("Testbench completed WITH ERRORS");
            end
        join_any
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/erm_pkg.sv
hw/rtl/erm_if.sv
hw/rtl/erm_isqrt.sv
hw/rtl/erm_cordic.sv
hw/rtl/erm_matrix.sv
hw/rtl/euler_rotation_matrix_top.sv
bench/tb_top.sv
